FILE: rtl/dncd_pkg.sv
// Shared constants and types for the depth neighbour-count speckle filter.
`timescale 1ns / 1ps
`default_nettype none

package dncd_pkg;

    // Line store geometry
    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    // Field and register widths
    localparam int DEPTH_W  = 16;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int THR_W    = 17;
    localparam int MIN_W    = 4;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int NB_W     = 8;
    localparam int CNT_W    = 4;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH    = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_DIFF_THRESHOLD = 2'd2,
        CFG_MIN_NEIGHBOURS = 2'd3
    } dncd_cfg_idx_t;

    // Input op codes
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } dncd_op_t;

    // One window column, top row first
    typedef struct packed {
        logic [DEPTH_W-1:0] top;
        logic [DEPTH_W-1:0] mid;
        logic [DEPTH_W-1:0] bot;
    } dncd_col_t;

    // Frame position of the pixel being judged
    typedef struct packed {
        logic [HEIGHT_W-1:0] row;
        logic [WIDTH_W-1:0]  col;
    } dncd_pos_t;

    // Judge result: similar-neighbour mask and last-pixel flag
    typedef struct packed {
        logic [NB_W-1:0] similar;
        logic            frame_end;
    } dncd_judge_t;

endpackage

`default_nettype wire

FILE: rtl/dncd_ram.sv
// Generic single-clock RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dncd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/dncd_judge.sv
// Neighbour comparison: eight masked threshold compares around the window centre.
`timescale 1ns / 1ps
`default_nettype none

module dncd_judge
    import dncd_pkg::*;
(
    input  wire dncd_col_t             left_col,
    input  wire dncd_col_t             mid_col,
    input  wire dncd_col_t             right_col,
    input  wire dncd_pos_t             pos,
    input  wire logic [WIDTH_W-1:0]    frame_width,
    input  wire logic [HEIGHT_W-1:0]   frame_height,
    input  wire logic [THR_W-1:0]      diff_threshold,
    output dncd_judge_t                result
);

    logic [DEPTH_W-1:0] centre;
    logic [DEPTH_W-1:0] nb [NB_W];
    logic [NB_W-1:0]    in_frame;
    logic               top_ok;
    logic               bot_ok;
    logic               left_ok;
    logic               right_ok;

    assign centre = mid_col.mid;

    // Neighbour order: top row left to right, middle left and right, bottom row
    assign nb[0] = left_col.top;
    assign nb[1] = mid_col.top;
    assign nb[2] = right_col.top;
    assign nb[3] = left_col.mid;
    assign nb[4] = right_col.mid;
    assign nb[5] = left_col.bot;
    assign nb[6] = mid_col.bot;
    assign nb[7] = right_col.bot;

    // Frame edges
    assign top_ok   = (pos.row != '0);
    assign bot_ok   = ((pos.row + HEIGHT_W'(1)) < frame_height);
    assign left_ok  = (pos.col != '0);
    assign right_ok = ((pos.col + WIDTH_W'(1)) < frame_width);

    assign in_frame[0] = top_ok & left_ok;
    assign in_frame[1] = top_ok;
    assign in_frame[2] = top_ok & right_ok;
    assign in_frame[3] = left_ok;
    assign in_frame[4] = right_ok;
    assign in_frame[5] = bot_ok & left_ok;
    assign in_frame[6] = bot_ok;
    assign in_frame[7] = bot_ok & right_ok;

    // Absolute difference against the threshold, per neighbour; last-pixel flag
    always_comb begin
        logic [DEPTH_W-1:0] diff;
        for (int i = 0; i < NB_W; i++) begin
            diff = (centre > nb[i]) ? (centre - nb[i]) : (nb[i] - centre);
            result.similar[i] = in_frame[i] & ({1'b0, diff} < diff_threshold);
        end
        result.frame_end = (pos.row == (frame_height - HEIGHT_W'(1)))
                         && (pos.col == (frame_width - WIDTH_W'(1)));
    end

endmodule

`default_nettype wire

FILE: rtl/depth_neighbour_count_denoise.sv
// Top level of the 3x3 neighbour-count speckle filter for 16-bit depth pixels.
// Throughput: one item per cycle; stalls only when the output is backpressured.
// Latency: a pixel's result leaves with the item that carries its right-hand
// column (one line plus one pixel of items later), then passes through the
// line store read, the compare stage and the output register.
// Reset (aresetn low, synchronous): clears position and drain state and sets
// the registers to 640, 480, 0, 0; the line store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module depth_neighbour_count_denoise
    import dncd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [DEPTH_W-1:0]   s_tdata,   // [15:0] depth_in
    input  wire logic                 s_tuser,   // [0] op
    // result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [DEPTH_W-1:0]   m_tdata,   // [15:0] depth_out
    output logic                      m_tlast,   // frame_end
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int RAM_W = 2 * DEPTH_W;
    localparam int ROW_EXT_W = HEIGHT_W + 1;

    // Configuration registers
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [THR_W-1:0]    thr_reg;
    logic [MIN_W-1:0]    min_reg;

    // Stream position
    logic [WIDTH_W-1:0]  col_reg,  col_next;
    logic [HEIGHT_W-1:0] row_reg,  row_next;
    logic                drain_reg, drain_next;

    // Stage 1: line store data arriving
    logic                s1_valid_reg;
    logic                s1_result_reg;
    logic                s1_pixel_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic [DEPTH_W-1:0]  s1_value_reg;
    dncd_pos_t           s1_pos_reg;

    // Window: the two most recent columns
    dncd_col_t           win_left_reg;
    dncd_col_t           win_mid_reg;

    // Stage 2: compare results
    logic                s2_valid_reg;
    dncd_judge_t         s2_judge_reg;
    logic [DEPTH_W-1:0]  s2_centre_reg;

    // Output register
    logic                m_valid_reg;
    logic [DEPTH_W-1:0]  m_data_reg;
    logic                m_last_reg;

    // Handshake and control
    logic                accept;
    logic                enter;
    logic                final_tick;
    logic                is_pixel;
    logic [ADDR_W-1:0]   rd_addr;
    logic                col_zero;
    logic [ROW_EXT_W-1:0] r_eff;
    logic                has_result;
    dncd_pos_t           pos_in;
    logic                m_ready_int;
    logic                s2_ready;
    logic                s1_depart;
    logic                s1_ready;

    logic [RAM_W-1:0]    ram_rdata;
    logic                ram_we;
    dncd_col_t           new_col;
    dncd_judge_t         judge_out;
    logic [CNT_W-1:0]    count;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;

    // Ready chain from the output back to the input
    assign m_ready_int = !m_valid_reg || m_tready;
    assign s2_ready    = !s2_valid_reg || m_ready_int;
    assign s1_depart   = s1_valid_reg && (!s1_result_reg || s2_ready);
    assign s1_ready    = !s1_valid_reg || s1_depart;
    assign s_tready    = s1_ready;
    assign accept      = s_tvalid && s_tready;

    // Item decode: a pixel while draining acts as a drain tick
    assign is_pixel   = !drain_reg && (s_tuser == OP_PIXEL);
    assign enter      = accept && (drain_reg || (s_tuser == OP_PIXEL));
    assign final_tick = drain_reg && (col_reg == width_reg);
    assign rd_addr    = final_tick ? '0 : col_reg[ADDR_W-1:0];
    assign col_zero   = (rd_addr == '0);

    // Row of the item, counting drain ticks as the rows below the frame
    always_comb begin
        if (!drain_reg) begin
            r_eff = {1'b0, row_reg};
        end else if (final_tick) begin
            r_eff = {1'b0, height_reg} + ROW_EXT_W'(1);
        end else begin
            r_eff = {1'b0, height_reg};
        end
    end

    // Pixel judged by this item: up and to the left of it, or last of the line two above
    always_comb begin
        if (col_zero) begin
            has_result = (r_eff >= ROW_EXT_W'(2));
            pos_in.row = HEIGHT_W'(r_eff - ROW_EXT_W'(2));
            pos_in.col = width_reg - WIDTH_W'(1);
        end else begin
            has_result = (r_eff >= ROW_EXT_W'(1));
            pos_in.row = HEIGHT_W'(r_eff - ROW_EXT_W'(1));
            pos_in.col = col_reg - WIDTH_W'(1);
        end
    end

    // Position advance; a geometry write restarts the frame
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        if (enter) begin
            if (drain_reg) begin
                if (final_tick) begin
                    col_next   = '0;
                    drain_next = 1'b0;
                end else begin
                    col_next = col_reg + WIDTH_W'(1);
                end
            end else if ((col_reg + WIDTH_W'(1)) == width_reg) begin
                col_next = '0;
                if ((row_reg + HEIGHT_W'(1)) == height_reg) begin
                    row_next   = '0;
                    drain_next = 1'b1;
                end else begin
                    row_next = row_reg + HEIGHT_W'(1);
                end
            end else begin
                col_next = col_reg + WIDTH_W'(1);
            end
        end
        if (cfg_we && (cfg_index inside {CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT})) begin
            col_next   = '0;
            row_next   = '0;
            drain_next = 1'b0;
        end
    end

    // Clamped register values
    always_comb begin
        cfg_width = cfg_data[WIDTH_W-1:0];
        if (cfg_width < WIDTH_W'(2)) begin
            cfg_width = WIDTH_W'(2);
        end else if (cfg_width > WIDTH_W'(MAX_WIDTH)) begin
            cfg_width = WIDTH_W'(MAX_WIDTH);
        end
        cfg_height = cfg_data[HEIGHT_W-1:0];
        if (cfg_height == '0) begin
            cfg_height = HEIGHT_W'(1);
        end
    end

    // Configuration and position registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            thr_reg    <= '0;
            min_reg    <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= 1'b0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_FRAME_WIDTH: begin
                        width_reg <= cfg_width;
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg <= cfg_height;
                    end
                    CFG_DIFF_THRESHOLD: begin
                        thr_reg <= cfg_data[THR_W-1:0];
                    end
                    CFG_MIN_NEIGHBOURS: begin
                        min_reg <= cfg_data[MIN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Line store: upper half is two lines back, lower half the last line
    assign ram_we = s1_depart && s1_pixel_reg;

    dncd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata ({ram_rdata[DEPTH_W-1:0], s1_value_reg}),
        .re    (enter),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_ready) begin
            s1_valid_reg <= enter;
        end
    end

    // Stage 1 payload
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_result_reg <= has_result;
            s1_pixel_reg  <= is_pixel;
            s1_addr_reg   <= rd_addr;
            s1_value_reg  <= s_tdata;
            s1_pos_reg    <= pos_in;
        end
    end

    // Incoming column; bottom is don't-care on drain ticks (below the frame)
    assign new_col.top = ram_rdata[RAM_W-1:DEPTH_W];
    assign new_col.mid = ram_rdata[DEPTH_W-1:0];
    assign new_col.bot = s1_value_reg;

    dncd_judge u_judge (
        .left_col       (win_left_reg),
        .mid_col        (win_mid_reg),
        .right_col      (new_col),
        .pos            (s1_pos_reg),
        .frame_width    (width_reg),
        .frame_height   (height_reg),
        .diff_threshold (thr_reg),
        .result         (judge_out)
    );

    // Window shift as each item leaves stage 1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg <= '0;
            win_mid_reg  <= '0;
        end else if (s1_depart) begin
            win_left_reg <= win_mid_reg;
            win_mid_reg  <= new_col;
        end
    end

    // Stage 2
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_depart && s1_result_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_ready) begin
            s2_judge_reg  <= judge_out;
            s2_centre_reg <= win_mid_reg.mid;
        end
    end

    // Similar-neighbour count
    always_comb begin
        count = '0;
        for (int i = 0; i < NB_W; i++) begin
            count = count + CNT_W'(s2_judge_reg.similar[i]);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_ready_int) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready_int) begin
            m_data_reg <= (count < min_reg) ? '0 : s2_centre_reg;
            m_last_reg <= s2_judge_reg.frame_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    // Input stalls only behind an occupied stage 1
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg)
        else $error("input stalled with stage 1 empty");

    // Line store never written and read at the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && enter) |-> (s1_addr_reg != rd_addr))
        else $error("line store read and write collide");

    // Column stays inside the line outside the drain phase
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !drain_reg |-> (col_reg < width_reg))
        else $error("column position beyond frame width");

    // Drain phase keeps the row at the frame start and the column within the frame width
    a_drain_row: assert property (@(posedge aclk) disable iff (!aresetn)
        drain_reg |-> (row_reg == '0) && (col_reg <= width_reg))
        else $error("drain phase with stray position");

    // A result enters stage 2 only from an item that carries one
    a_s2_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_ready && s1_depart && !s1_result_reg) |=> !s2_valid_reg)
        else $error("stage 2 loaded by an item without a result");
`endif

endmodule

`default_nettype wire
